[rtl/core/gfa_pkg.sv]
package gfa_pkg;

  // Grid geometry and owner id width
  localparam int MAX_ROWS    = 8;
  localparam int MAX_COLUMNS = 8;
  localparam int ID_WIDTH    = 8;

  localparam int CELL_COUNT = MAX_ROWS * MAX_COLUMNS;
  localparam int CELL_W     = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam int ROW_W      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_W      = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

  // Width of the grid size registers and the rectangle size fields
  localparam int DIM_W = 4;
  // Width of the reported position fields
  localparam int POS_OUT_W = 3;
  // Width that holds a position plus a size without overflow
  localparam int SUM_MAX = (ROW_W > COL_W) ? ((ROW_W > DIM_W) ? ROW_W : DIM_W)
                                           : ((COL_W > DIM_W) ? COL_W : DIM_W);
  localparam int SUM_W   = SUM_MAX + 1;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [DIM_W-1:0] GRID_ROWS_RESET    = DIM_W'(8);
  localparam logic [DIM_W-1:0] GRID_COLUMNS_RESET = DIM_W'(8);

  typedef enum logic [0:0] {
    REG_GRID_ROWS    = 1'b0,
    REG_GRID_COLUMNS = 1'b1
  } reg_index_t;

  // Request kinds
  localparam logic KIND_PLACE  = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  // Datapath actions driven by the control word
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_LATCH,
    ACT_PROBE,
    ACT_MARK,
    ACT_READ,
    ACT_CHECK,
    ACT_REPORT
  } act_t;

  // Jump conditions
  typedef enum logic [3:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_INPUT,
    COND_INVALID,
    COND_REMOVE,
    COND_SCAN_MORE,
    COND_NOT_FOUND,
    COND_SWEEP_MORE,
    COND_OUT_FULL
  } cond_t;

  localparam int PC_W = 4;
  typedef logic [PC_W-1:0] pc_t;

  // Program addresses
  localparam pc_t PC_REPORT     = PC_W'(0);
  localparam pc_t PC_WAIT       = PC_W'(1);
  localparam pc_t PC_DISPATCH   = PC_W'(2);
  localparam pc_t PC_BRANCH     = PC_W'(3);
  localparam pc_t PC_PROBE      = PC_W'(4);
  localparam pc_t PC_FOUND      = PC_W'(5);
  localparam pc_t PC_MARK       = PC_W'(6);
  localparam pc_t PC_MARK_DONE  = PC_W'(7);
  localparam pc_t PC_READ       = PC_W'(8);
  localparam pc_t PC_CHECK      = PC_W'(9);
  localparam pc_t PC_CHECK_DONE = PC_W'(10);

  typedef struct packed {
    act_t  act;
    cond_t cond;
    pc_t   target;
  } uword_t;

  typedef struct packed {
    logic in_valid;
    logic invalid;
    logic remove;
    logic scan_more;
    logic found;
    logic sweep_more;
    logic out_full;
  } dp_status_t;

endpackage

[rtl/core/gfa_ucode_rom.sv]
module gfa_ucode_rom (
  input  gfa_pkg::pc_t   pc,
  output gfa_pkg::uword_t word
);

  // Control store: jump to target when the condition holds, else step on
  always_comb begin
    unique case (pc)
      gfa_pkg::PC_REPORT:
        word = '{gfa_pkg::ACT_REPORT, gfa_pkg::COND_OUT_FULL, gfa_pkg::PC_REPORT};
      gfa_pkg::PC_WAIT:
        word = '{gfa_pkg::ACT_LATCH, gfa_pkg::COND_NO_INPUT, gfa_pkg::PC_WAIT};
      gfa_pkg::PC_DISPATCH:
        word = '{gfa_pkg::ACT_NONE, gfa_pkg::COND_INVALID, gfa_pkg::PC_REPORT};
      gfa_pkg::PC_BRANCH:
        word = '{gfa_pkg::ACT_NONE, gfa_pkg::COND_REMOVE, gfa_pkg::PC_READ};
      gfa_pkg::PC_PROBE:
        word = '{gfa_pkg::ACT_PROBE, gfa_pkg::COND_SCAN_MORE, gfa_pkg::PC_PROBE};
      gfa_pkg::PC_FOUND:
        word = '{gfa_pkg::ACT_NONE, gfa_pkg::COND_NOT_FOUND, gfa_pkg::PC_REPORT};
      gfa_pkg::PC_MARK:
        word = '{gfa_pkg::ACT_MARK, gfa_pkg::COND_SWEEP_MORE, gfa_pkg::PC_MARK};
      gfa_pkg::PC_MARK_DONE:
        word = '{gfa_pkg::ACT_NONE, gfa_pkg::COND_ALWAYS, gfa_pkg::PC_REPORT};
      gfa_pkg::PC_READ:
        word = '{gfa_pkg::ACT_READ, gfa_pkg::COND_NEVER, gfa_pkg::PC_READ};
      gfa_pkg::PC_CHECK:
        word = '{gfa_pkg::ACT_CHECK, gfa_pkg::COND_SWEEP_MORE, gfa_pkg::PC_READ};
      gfa_pkg::PC_CHECK_DONE:
        word = '{gfa_pkg::ACT_NONE, gfa_pkg::COND_ALWAYS, gfa_pkg::PC_REPORT};
      default:
        word = '{gfa_pkg::ACT_NONE, gfa_pkg::COND_ALWAYS, gfa_pkg::PC_WAIT};
    endcase
  end

endmodule

[rtl/core/gfa_sequencer.sv]
module gfa_sequencer (
  input  logic                clk,
  input  logic                rst,
  input  gfa_pkg::dp_status_t status,
  output gfa_pkg::uword_t     word
);

  gfa_pkg::pc_t pc;
  gfa_pkg::pc_t pc_next;
  logic         take_jump;

  gfa_ucode_rom u_rom (
    .pc   (pc),
    .word (word)
  );

  // Evaluate the jump condition of the current step
  always_comb begin
    unique case (word.cond)
      gfa_pkg::COND_NEVER:      take_jump = 1'b0;
      gfa_pkg::COND_ALWAYS:     take_jump = 1'b1;
      gfa_pkg::COND_NO_INPUT:   take_jump = !status.in_valid;
      gfa_pkg::COND_INVALID:    take_jump = status.invalid;
      gfa_pkg::COND_REMOVE:     take_jump = status.remove;
      gfa_pkg::COND_SCAN_MORE:  take_jump = status.scan_more;
      gfa_pkg::COND_NOT_FOUND:  take_jump = !status.found;
      gfa_pkg::COND_SWEEP_MORE: take_jump = status.sweep_more;
      gfa_pkg::COND_OUT_FULL:   take_jump = status.out_full;
      default:                  take_jump = 1'b1;
    endcase
    pc_next = take_jump ? word.target : pc + gfa_pkg::PC_W'(1);
  end

  // Advance the step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= gfa_pkg::PC_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

[rtl/core/gfa_datapath.sv]
module gfa_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  gfa_pkg::act_t                       act,
  input  logic [gfa_pkg::DIM_W-1:0]           grid_rows,
  input  logic [gfa_pkg::DIM_W-1:0]           grid_columns,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                kind,
  input  logic [gfa_pkg::ID_WIDTH-1:0]        item_id,
  input  logic [gfa_pkg::DIM_W-1:0]           item_width,
  input  logic [gfa_pkg::DIM_W-1:0]           item_height,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                success,
  output logic [gfa_pkg::POS_OUT_W-1:0]       place_column,
  output logic [gfa_pkg::POS_OUT_W-1:0]       place_row,
  output gfa_pkg::dp_status_t                 status
);

  localparam int SW = gfa_pkg::SUM_W;

  // Latched request
  logic                            kind_r;
  logic [gfa_pkg::ID_WIDTH-1:0]    id_r;
  logic [gfa_pkg::DIM_W-1:0]       w_r;
  logic [gfa_pkg::DIM_W-1:0]       h_r;

  // Scan position, sweep index, result flag, occupancy
  logic [gfa_pkg::ROW_W-1:0]       row_pos;
  logic [gfa_pkg::COL_W-1:0]       col_pos;
  logic [gfa_pkg::CELL_W-1:0]      cnt;
  logic                            res_ok;
  logic [gfa_pkg::CELL_COUNT-1:0]  occ;

  // Owner id store
  logic [gfa_pkg::ID_WIDTH-1:0]    mem [gfa_pkg::CELL_COUNT];
  logic [gfa_pkg::ID_WIDTH-1:0]    rd_data;

  logic [SW-1:0]                   rows_eff;
  logic [SW-1:0]                   cols_eff;
  logic [SW-1:0]                   row_end;
  logic [SW-1:0]                   col_end;
  logic                            in_bounds;
  logic                            fit;
  logic                            last_pos;
  logic                            out_full;
  logic [gfa_pkg::CELL_COUNT-1:0]  mask;

  // Clamp the active grid to 1..max
  always_comb begin
    if (grid_rows == '0) begin
      rows_eff = SW'(1);
    end else if (SW'(grid_rows) > SW'(gfa_pkg::MAX_ROWS)) begin
      rows_eff = SW'(gfa_pkg::MAX_ROWS);
    end else begin
      rows_eff = SW'(grid_rows);
    end
    if (grid_columns == '0) begin
      cols_eff = SW'(1);
    end else if (SW'(grid_columns) > SW'(gfa_pkg::MAX_COLUMNS)) begin
      cols_eff = SW'(gfa_pkg::MAX_COLUMNS);
    end else begin
      cols_eff = SW'(grid_columns);
    end
  end

  // Rectangle footprint at the current candidate
  always_comb begin
    row_end   = SW'(row_pos) + SW'(h_r);
    col_end   = SW'(col_pos) + SW'(w_r);
    in_bounds = (col_end <= cols_eff) && (row_end <= rows_eff);
    for (int i = 0; i < gfa_pkg::CELL_COUNT; i++) begin
      mask[i] = (SW'(i / gfa_pkg::MAX_COLUMNS) >= SW'(row_pos)) &&
                (SW'(i / gfa_pkg::MAX_COLUMNS) < row_end) &&
                (SW'(i % gfa_pkg::MAX_COLUMNS) >= SW'(col_pos)) &&
                (SW'(i % gfa_pkg::MAX_COLUMNS) < col_end);
    end
    fit      = in_bounds && ((occ & mask) == '0);
    last_pos = (SW'(row_pos) == rows_eff - SW'(1)) &&
               (SW'(col_pos) == cols_eff - SW'(1));
    out_full = out_valid && out_stall;
  end

  // Status toward the sequencer
  always_comb begin
    in_stall          = (act != gfa_pkg::ACT_LATCH);
    status.in_valid   = in_valid;
    status.invalid    = (id_r == '0) ||
                        ((kind_r == gfa_pkg::KIND_PLACE) && ((w_r == '0) || (h_r == '0)));
    status.remove     = (kind_r == gfa_pkg::KIND_REMOVE);
    status.scan_more  = !fit && !last_pos;
    status.found      = res_ok;
    status.sweep_more = (cnt != gfa_pkg::CELL_W'(gfa_pkg::CELL_COUNT - 1));
    status.out_full   = out_full;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      row_pos   <= '0;
      col_pos   <= '0;
      cnt       <= '0;
      res_ok    <= 1'b0;
      occ       <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (act)
        gfa_pkg::ACT_LATCH: begin
          if (in_valid) begin
            row_pos <= '0;
            col_pos <= '0;
            cnt     <= '0;
            res_ok  <= 1'b0;
          end
        end
        gfa_pkg::ACT_PROBE: begin
          if (fit) begin
            res_ok <= 1'b1;
          end else if (!last_pos) begin
            if (SW'(col_pos) == cols_eff - SW'(1)) begin
              col_pos <= '0;
              row_pos <= row_pos + gfa_pkg::ROW_W'(1);
            end else begin
              col_pos <= col_pos + gfa_pkg::COL_W'(1);
            end
          end
        end
        gfa_pkg::ACT_MARK: begin
          if (mask[cnt]) begin
            occ[cnt] <= 1'b1;
          end
          cnt <= cnt + gfa_pkg::CELL_W'(1);
        end
        gfa_pkg::ACT_CHECK: begin
          if (occ[cnt] && (rd_data == id_r)) begin
            occ[cnt] <= 1'b0;
            res_ok   <= 1'b1;
          end
          cnt <= cnt + gfa_pkg::CELL_W'(1);
        end
        default: begin
        end
      endcase
      // Load the result register when free, drop it once taken
      if ((act == gfa_pkg::ACT_REPORT) && !out_full) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Request and result payload
  always_ff @(posedge clk) begin
    if ((act == gfa_pkg::ACT_LATCH) && in_valid) begin
      kind_r <= kind;
      id_r   <= item_id;
      w_r    <= item_width;
      h_r    <= item_height;
    end
    if ((act == gfa_pkg::ACT_REPORT) && !out_full) begin
      success <= res_ok;
      if (res_ok && (kind_r == gfa_pkg::KIND_PLACE)) begin
        place_column <= gfa_pkg::POS_OUT_W'(col_pos);
        place_row    <= gfa_pkg::POS_OUT_W'(row_pos);
      end else begin
        place_column <= '0;
        place_row    <= '0;
      end
    end
  end

  // Owner id store: write on mark, registered read on sweep
  always_ff @(posedge clk) begin
    if ((act == gfa_pkg::ACT_MARK) && mask[cnt]) begin
      mem[cnt] <= id_r;
    end
    if (act == gfa_pkg::ACT_READ) begin
      rd_data <= mem[cnt];
    end
  end

endmodule

[rtl/core/grid_rectangle_first_fit_allocator.sv]
// First-fit rectangle allocator over an 8 x 8 grid of owner ids, driven by a small
// microcoded sequencer. A place request is first checked and dispatched, then probes one
// candidate top-left position per cycle in row-major order, and on a fit sweeps the
// 64-entry owner store once, one cell per cycle, to write the id. A remove request
// reads and compares every cell of the store through its single registered read port,
// with a read step and then a check step for each cell. A request with id 0, or a
// place with zero size, is answered as a failure without a scan. One request is in
// work at a time; the result register frees the sequencer, so the next request is
// taken while a result still waits. The cell occupancy lives in flip-flops that reset
// clears; no clearing pass follows reset.
module grid_rectangle_first_fit_allocator (
  input  logic                               clk,
  input  logic                               rst,
  // Configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [gfa_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [gfa_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [gfa_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                               pready,
  // Request channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               kind,
  input  logic [gfa_pkg::ID_WIDTH-1:0]       item_id,
  input  logic [gfa_pkg::DIM_W-1:0]          item_width,
  input  logic [gfa_pkg::DIM_W-1:0]          item_height,
  // Result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               success,
  output logic [gfa_pkg::POS_OUT_W-1:0]      place_column,
  output logic [gfa_pkg::POS_OUT_W-1:0]      place_row
);

  logic [gfa_pkg::DIM_W-1:0] grid_rows;
  logic [gfa_pkg::DIM_W-1:0] grid_columns;
  gfa_pkg::reg_index_t       reg_sel;
  logic                      cfg_write;
  gfa_pkg::uword_t           word;
  gfa_pkg::dp_status_t       status;

  assign pready    = 1'b1;
  assign reg_sel   = gfa_pkg::reg_index_t'(paddr[2]);
  assign cfg_write = psel && penable && pwrite && pready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows    <= gfa_pkg::GRID_ROWS_RESET;
      grid_columns <= gfa_pkg::GRID_COLUMNS_RESET;
    end else if (cfg_write) begin
      unique case (reg_sel)
        gfa_pkg::REG_GRID_ROWS:    grid_rows    <= pwdata[gfa_pkg::DIM_W-1:0];
        gfa_pkg::REG_GRID_COLUMNS: grid_columns <= pwdata[gfa_pkg::DIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Register readback
  always_comb begin
    unique case (reg_sel)
      gfa_pkg::REG_GRID_ROWS:
        prdata = gfa_pkg::CFG_DATA_W'(grid_rows);
      gfa_pkg::REG_GRID_COLUMNS:
        prdata = gfa_pkg::CFG_DATA_W'(grid_columns);
      default:
        prdata = '0;
    endcase
  end

  gfa_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .word   (word)
  );

  gfa_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .act          (word.act),
    .grid_rows    (grid_rows),
    .grid_columns (grid_columns),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .kind         (kind),
    .item_id      (item_id),
    .item_width   (item_width),
    .item_height  (item_height),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .success      (success),
    .place_column (place_column),
    .place_row    (place_row),
    .status       (status)
  );

  // A failed transaction reports position zero
  a_fail_pos_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !success) |-> ((place_column == '0) && (place_row == '0)))
    else $error("failed result carries a nonzero position");

  // An accepted request keeps the block busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request channel open right after acceptance");

  // A new result is only loaded while a request is in work
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared while idle");

endmodule

[tb/grid_rectangle_first_fit_allocator_test.sv]
module grid_rectangle_first_fit_allocator_test;

  typedef struct packed {
    logic                         kind;
    logic [gfa_pkg::ID_WIDTH-1:0] id;
    logic [gfa_pkg::DIM_W-1:0]    width;
    logic [gfa_pkg::DIM_W-1:0]    height;
  } alloc_req_t;

  typedef struct packed {
    logic                          success;
    logic [gfa_pkg::POS_OUT_W-1:0] column;
    logic [gfa_pkg::POS_OUT_W-1:0] row;
  } alloc_resp_t;

  typedef struct packed {
    alloc_req_t  req;
    logic        typed;
    alloc_resp_t resp;
  } directed_row_t;

  localparam alloc_resp_t FAIL_RESP = '0;
  localparam alloc_resp_t ORIGIN_RESP = '{1'b1, 3'd0, 3'd0};
  localparam int IDLE_LIMIT = 2000;
  localparam int TAIL_CYCLES = 200;
  localparam int PHASE_ITEMS = 95;
  localparam int DIRECTED_COUNT = 25;

  // Rows with a typed expectation are checked against it; the others go through the predictor
  directed_row_t directed_rows [DIRECTED_COUNT] = '{
    '{'{gfa_pkg::KIND_PLACE,  8'd1,   4'd8,  4'd8},  1'b1, ORIGIN_RESP},
    '{'{gfa_pkg::KIND_PLACE,  8'd2,   4'd1,  4'd1},  1'b1, FAIL_RESP},
    '{'{gfa_pkg::KIND_REMOVE, 8'd1,   4'd0,  4'd0},  1'b1, ORIGIN_RESP},
    '{'{gfa_pkg::KIND_REMOVE, 8'd1,   4'd0,  4'd0},  1'b1, FAIL_RESP},
    '{'{gfa_pkg::KIND_PLACE,  8'd0,   4'd1,  4'd1},  1'b1, FAIL_RESP},
    '{'{gfa_pkg::KIND_REMOVE, 8'd0,   4'd15, 4'd15}, 1'b1, FAIL_RESP},
    '{'{gfa_pkg::KIND_PLACE,  8'd3,   4'd0,  4'd1},  1'b1, FAIL_RESP},
    '{'{gfa_pkg::KIND_PLACE,  8'd3,   4'd1,  4'd0},  1'b1, FAIL_RESP},
    '{'{gfa_pkg::KIND_PLACE,  8'd3,   4'd9,  4'd1},  1'b1, FAIL_RESP},
    '{'{gfa_pkg::KIND_PLACE,  8'd3,   4'd15, 4'd15}, 1'b1, FAIL_RESP},
    '{'{gfa_pkg::KIND_PLACE,  8'd3,   4'd1,  4'd9},  1'b1, FAIL_RESP},
    '{'{gfa_pkg::KIND_PLACE,  8'd255, 4'd1,  4'd1},  1'b1, ORIGIN_RESP},
    '{'{gfa_pkg::KIND_PLACE,  8'd255, 4'd2,  4'd3},  1'b0, FAIL_RESP},
    '{'{gfa_pkg::KIND_PLACE,  8'd4,   4'd7,  4'd1},  1'b0, FAIL_RESP},
    '{'{gfa_pkg::KIND_PLACE,  8'd5,   4'd8,  4'd1},  1'b0, FAIL_RESP},
    '{'{gfa_pkg::KIND_PLACE,  8'd6,   4'd3,  4'd2},  1'b0, FAIL_RESP},
    '{'{gfa_pkg::KIND_PLACE,  8'd128, 4'd1,  4'd8},  1'b0, FAIL_RESP},
    '{'{gfa_pkg::KIND_PLACE,  8'd255, 4'd8,  4'd1},  1'b0, FAIL_RESP},
    '{'{gfa_pkg::KIND_REMOVE, 8'd255, 4'd0,  4'd0},  1'b1, ORIGIN_RESP},
    '{'{gfa_pkg::KIND_REMOVE, 8'd4,   4'd0,  4'd0},  1'b0, FAIL_RESP},
    '{'{gfa_pkg::KIND_REMOVE, 8'd5,   4'd0,  4'd0},  1'b0, FAIL_RESP},
    '{'{gfa_pkg::KIND_REMOVE, 8'd6,   4'd0,  4'd0},  1'b0, FAIL_RESP},
    '{'{gfa_pkg::KIND_REMOVE, 8'd128, 4'd0,  4'd0},  1'b0, FAIL_RESP},
    '{'{gfa_pkg::KIND_PLACE,  8'd170, 4'd8,  4'd8},  1'b0, FAIL_RESP},
    '{'{gfa_pkg::KIND_REMOVE, 8'd170, 4'd0,  4'd0},  1'b0, FAIL_RESP}
  };

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           psel = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite = 1'b0;
  logic [gfa_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [gfa_pkg::CFG_DATA_W-1:0] pwdata = '0;
  logic [gfa_pkg::CFG_DATA_W-1:0] prdata;
  logic                           pready;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic                           kind = gfa_pkg::KIND_PLACE;
  logic [gfa_pkg::ID_WIDTH-1:0]   item_id = '0;
  logic [gfa_pkg::DIM_W-1:0]      item_width = '0;
  logic [gfa_pkg::DIM_W-1:0]      item_height = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic                           success;
  logic [gfa_pkg::POS_OUT_W-1:0]  place_column;
  logic [gfa_pkg::POS_OUT_W-1:0]  place_row;

  // Predicted grid contents and register settings
  logic [gfa_pkg::ID_WIDTH-1:0] owner_map [gfa_pkg::CELL_COUNT];
  logic [gfa_pkg::DIM_W-1:0]    rows_setting = gfa_pkg::GRID_ROWS_RESET;
  logic [gfa_pkg::DIM_W-1:0]    columns_setting = gfa_pkg::GRID_COLUMNS_RESET;

  alloc_resp_t pending_outcomes [$];
  alloc_resp_t oldest_outcome;
  int          mismatch_count = 0;
  int          idle_cycles = 0;
  int          hold_cycles = 0;
  int          drawn_hold;
  bit          quiet = 1'b0;

  grid_rectangle_first_fit_allocator dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .kind(kind), .item_id(item_id),
    .item_width(item_width), .item_height(item_height),
    .out_valid(out_valid), .out_stall(out_stall), .success(success),
    .place_column(place_column), .place_row(place_row)
  );

  always #5 clk = ~clk;

  // Compute the outcome of one request and apply it to the predicted grid
  function automatic alloc_resp_t grid_outcome(alloc_req_t req);
    alloc_resp_t resp;
    int rows, cols, r, c, rr, cc;
    bit fits;
    resp = '0;
    rows = (rows_setting == 0) ? 1
         : (rows_setting > gfa_pkg::MAX_ROWS) ? gfa_pkg::MAX_ROWS : rows_setting;
    cols = (columns_setting == 0) ? 1
         : (columns_setting > gfa_pkg::MAX_COLUMNS) ? gfa_pkg::MAX_COLUMNS : columns_setting;
    if (req.id == 0) return resp;
    // Remove sweeps the whole store, inactive cells included
    if (req.kind == gfa_pkg::KIND_REMOVE) begin
      for (int i = 0; i < gfa_pkg::CELL_COUNT; i++) begin
        if (owner_map[i] == req.id) begin
          owner_map[i] = '0;
          resp.success = 1'b1;
        end
      end
      return resp;
    end
    if (req.width == 0 || req.height == 0) return resp;
    // Scan top-left corners row by row, first fit wins
    for (r = 0; r < rows; r++) begin
      for (c = 0; c < cols; c++) begin
        if (c + req.width > cols || r + req.height > rows) continue;
        fits = 1'b1;
        for (rr = r; rr < r + req.height; rr++)
          for (cc = c; cc < c + req.width; cc++)
            if (owner_map[rr * gfa_pkg::MAX_COLUMNS + cc] != 0) fits = 1'b0;
        if (fits) begin
          for (rr = r; rr < r + req.height; rr++)
            for (cc = c; cc < c + req.width; cc++)
              owner_map[rr * gfa_pkg::MAX_COLUMNS + cc] = req.id;
          resp.success = 1'b1;
          resp.column = gfa_pkg::POS_OUT_W'(c);
          resp.row = gfa_pkg::POS_OUT_W'(r);
          return resp;
        end
      end
    end
    return resp;
  endfunction

  // Drive one request after a random gap and queue its outcome once accepted
  task automatic issue_request(alloc_req_t req, logic typed, alloc_resp_t typed_resp);
    int gap;
    alloc_resp_t predicted;
    gap = quiet ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= req.kind;
    item_id <= req.id;
    item_width <= req.width;
    item_height <= req.height;
    do @(posedge clk); while (in_stall !== 1'b0);
    predicted = grid_outcome(req);
    pending_outcomes.push_back(typed ? typed_resp : predicted);
  endtask

  // Write one register through a setup phase and an access phase, then idle the port
  task automatic write_register(gfa_pkg::reg_index_t index, logic [gfa_pkg::DIM_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {index, 2'b00};
    pwdata <= gfa_pkg::CFG_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (index)
      gfa_pkg::REG_GRID_ROWS:    rows_setting = value;
      gfa_pkg::REG_GRID_COLUMNS: columns_setting = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Drain, reconfigure, then send a batch of random requests
  task automatic run_phase(logic [gfa_pkg::DIM_W-1:0] rows_value,
                           logic [gfa_pkg::DIM_W-1:0] cols_value);
    alloc_req_t req;
    while (pending_outcomes.size() != 0) @(posedge clk);
    write_register(gfa_pkg::REG_GRID_ROWS, rows_value);
    write_register(gfa_pkg::REG_GRID_COLUMNS, cols_value);
    quiet = ($urandom_range(0, 3) == 0);
    repeat (PHASE_ITEMS) begin
      req.kind = ($urandom_range(0, 99) < 40) ? gfa_pkg::KIND_REMOVE : gfa_pkg::KIND_PLACE;
      // Keep most ids in a small pool so removes find their owners
      if ($urandom_range(0, 9) == 0) req.id = gfa_pkg::ID_WIDTH'($urandom_range(0, 255));
      else req.id = gfa_pkg::ID_WIDTH'($urandom_range(1, 12));
      if ($urandom_range(0, 9) == 0) begin
        req.width = gfa_pkg::DIM_W'($urandom_range(0, 15));
        req.height = gfa_pkg::DIM_W'($urandom_range(0, 15));
      end else begin
        req.width = gfa_pkg::DIM_W'($urandom_range(1, 4));
        req.height = gfa_pkg::DIM_W'($urandom_range(1, 4));
      end
      issue_request(req, 1'b0, FAIL_RESP);
    end
    in_valid <= 1'b0;
  endtask

  // Check results, pace the result stall and count idle cycles
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)
          || (psel && penable && pwrite && pready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;

      if (out_valid && !out_stall) begin
        if (pending_outcomes.size() == 0) begin
          $error("result transaction with no request outstanding");
          mismatch_count++;
        end else begin
          oldest_outcome = pending_outcomes.pop_front();
          if (success !== oldest_outcome.success) begin
            $error("success: expected %0d, got %0d", oldest_outcome.success, success);
            mismatch_count++;
          end
          if (place_column !== oldest_outcome.column) begin
            $error("place_column: expected %0d, got %0d", oldest_outcome.column, place_column);
            mismatch_count++;
          end
          if (place_row !== oldest_outcome.row) begin
            $error("place_row: expected %0d, got %0d", oldest_outcome.row, place_row);
            mismatch_count++;
          end
        end
        drawn_hold = quiet ? 0 : $urandom_range(0, 10);
        hold_cycles <= drawn_hold;
        out_stall <= (drawn_hold != 0);
      end else if (hold_cycles > 1) begin
        hold_cycles <= hold_cycles - 1;
      end else begin
        hold_cycles <= 0;
        out_stall <= 1'b0;
      end
    end
  end

  // End the run when nothing moves for too long
  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    for (int i = 0; i < gfa_pkg::CELL_COUNT; i++) owner_map[i] = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed requests at the reset grid size
    for (int i = 0; i < DIRECTED_COUNT; i++)
      issue_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].resp);
    in_valid <= 1'b0;

    // Random requests over several grid sizes, out-of-range settings included
    run_phase(4'd8, 4'd8);
    run_phase(4'd3, 4'd5);
    run_phase(4'd1, 4'd1);
    run_phase(4'd0, 4'd0);
    run_phase(4'd15, 4'd15);
    run_phase(4'd8, 4'd1);
    run_phase(4'd2, 4'd8);
    run_phase(4'd9, 4'd12);
    run_phase(gfa_pkg::DIM_W'($urandom_range(0, 15)), gfa_pkg::DIM_W'($urandom_range(0, 15)));
    run_phase(gfa_pkg::DIM_W'($urandom_range(1, 8)), gfa_pkg::DIM_W'($urandom_range(1, 8)));

    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

[sim.f]
rtl/core/gfa_pkg.sv
rtl/core/gfa_ucode_rom.sv
rtl/core/gfa_sequencer.sv
rtl/core/gfa_datapath.sv
rtl/core/grid_rectangle_first_fit_allocator.sv
tb/grid_rectangle_first_fit_allocator_test.sv
